### rtl/core/clgt_pkg.sv
// ----------------------------------------------------------------------------
// clgt_pkg
// Shared types and constants for the caching lock grant table.
// ----------------------------------------------------------------------------
`default_nettype none

package clgt_pkg;

  localparam int LOCK_COUNT   = 256;
  localparam int CLIENT_COUNT = 16;
  localparam int LOCK_W       = $clog2(LOCK_COUNT);
  localparam int CLIENT_W     = $clog2(CLIENT_COUNT);

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RETRY = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef logic [CLIENT_W-1:0]     client_t;
  typedef logic [LOCK_W-1:0]       lock_idx_t;
  typedef logic [CLIENT_COUNT-1:0] client_mask_t;

  typedef struct packed {
    logic         locked;
    logic         holder_valid;
    client_t      holder;
    logic         succ_valid;
    client_t      succ;
    client_mask_t waiters;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/caching_lock_grant_table_core.sv
// ----------------------------------------------------------------------------
// caching_lock_grant_table_core
// Lock table serving acquire and release requests with revoke hints.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): opcode, lock_number, client. One request
// per transfer; each request yields exactly one result transfer on the output
// channel (out_valid/out_ready): status, revoke_send, revoke_target,
// revoke_successor.
// Each request goes through two steps: the registered read of the lock entry
// from the table RAM, then the update of the entry, its write-back and the
// load of the result register. A new request is accepted only once the last
// one has left its update step, also while a finished result still waits.
// If the receiver stalls, the block holds the next request in its update step
// until the result register frees up, and in_ready stays low meanwhile.
// Reset clears the per-entry valid bits at once, so every lock reads as free,
// unreserved and with no waiters; no clearing pass is needed and the first
// request is accepted right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module caching_lock_grant_table_core import clgt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       opcode,
  input  wire logic [7:0] lock_number,
  input  wire logic [3:0] client,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      status,
  output logic            revoke_send,
  output logic [3:0]      revoke_target,
  output logic [3:0]      revoke_successor
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  clgt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  clgt_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .opcode          (opcode),
    .lock_number     (lock_number),
    .client          (client),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .revoke_send     (revoke_send),
    .revoke_target   (revoke_target),
    .revoke_successor(revoke_successor)
  );

endmodule

`default_nettype wire

### rtl/core/clgt_ram.sv
// ----------------------------------------------------------------------------
// clgt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/clgt_ctrl.sv
// ----------------------------------------------------------------------------
// clgt_ctrl
// Request sequencer: capture and table read, then update and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module clgt_ctrl import clgt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t sts,
  output ctrl_cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && (state == S_IDLE);
  assign cmd.commit  = (state == S_EXEC) && sts.out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/clgt_dpath.sv
// ----------------------------------------------------------------------------
// clgt_dpath
// Lock table datapath: entry RAM, entry valid bits, update logic, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module clgt_dpath import clgt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     sts,
  input  wire logic      opcode,
  input  wire logic [7:0] lock_number,
  input  wire logic [3:0] client,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [1:0]     status,
  output logic           revoke_send,
  output logic [3:0]     revoke_target,
  output logic [3:0]     revoke_successor
);

  function automatic client_t lowest_waiter(input client_mask_t m);
    client_t r;
    r = '0;
    for (int i = CLIENT_COUNT - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = CLIENT_W'(i);
      end
    end
    return r;
  endfunction

  logic                  op_q;
  lock_idx_t             lock_q;
  client_t               client_q;
  logic                  ent_valid_q;
  logic [LOCK_COUNT-1:0] ent_vld;

  lock_idx_t             rd_idx;
  logic [ENTRY_W-1:0]    rdata;
  entry_t                cur;
  entry_t                upd;
  client_mask_t          cbit;
  client_mask_t          rest;
  client_t               nx;
  logic                  res_free;
  logic                  revoke;
  logic [1:0]            status_next;
  logic                  send_next;
  logic [3:0]            target_next;
  logic [3:0]            succ_next;

  assign rd_idx = lock_number[LOCK_W-1:0];

  clgt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(LOCK_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (cmd.commit),
    .waddr(lock_q),
    .wdata(upd),
    .re   (cmd.capture),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q        <= opcode;
      lock_q      <= rd_idx;
      client_q    <= client[CLIENT_W-1:0];
      ent_valid_q <= ent_vld[rd_idx];
    end
  end

  // entry written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
    end else if (cmd.commit) begin
      ent_vld[lock_q] <= 1'b1;
    end
  end

  // entry update
  always_comb begin
    cur         = ent_valid_q ? entry_t'(rdata) : '0;
    upd         = cur;
    cbit        = client_mask_t'(1) << client_q;
    rest        = cur.waiters & ~cbit;
    nx          = lowest_waiter(rest);
    res_free    = !cur.succ_valid || (cur.succ == client_q);
    revoke      = 1'b0;
    status_next = ST_OK;
    if (op_q == OP_RELEASE) begin
      if (!cur.locked || !cur.holder_valid || (cur.holder != client_q)) begin
        status_next = ST_ERROR;
      end else begin
        upd.locked       = 1'b0;
        upd.holder_valid = 1'b0;
        upd.holder       = '0;
      end
    end else if (!cur.locked && res_free) begin
      upd.locked       = 1'b1;
      upd.holder_valid = 1'b1;
      upd.holder       = client_q;
      upd.succ_valid   = 1'b0;
      upd.succ         = '0;
      upd.waiters      = rest;
      if (rest != '0) begin
        revoke         = 1'b1;
        upd.succ_valid = 1'b1;
        upd.succ       = nx;
        upd.waiters    = rest & ~(client_mask_t'(1) << nx);
      end
    end else if (res_free) begin
      upd.succ_valid = 1'b1;
      upd.succ       = client_q;
      upd.waiters    = rest;
      revoke         = 1'b1;
      status_next    = ST_RETRY;
    end else begin
      upd.waiters = cur.waiters | cbit;
      revoke      = 1'b1;
      status_next = ST_RETRY;
    end
    send_next   = revoke && upd.holder_valid;
    target_next = send_next ? 4'(upd.holder) : 4'd0;
    succ_next   = (send_next && upd.succ_valid) ? 4'(upd.succ) : 4'd0;
  end

  assign sts.out_free = !out_valid || out_ready;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status           <= status_next;
      revoke_send      <= send_next;
      revoke_target    <= target_next;
      revoke_successor <= succ_next;
    end
  end

endmodule

`default_nettype wire

### bench/caching_lock_grant_table_core_tb.sv
// ----------------------------------------------------------------------------
// caching_lock_grant_table_core_tb
// Self-checking bench for the lock grant table. A short table of directed
// requests covers grants, retries, reservations, waiter promotion, revokes
// with and without a holder and bad releases. It is followed by random traffic
// focused on a few contended locks. A behavioral copy of the table predicts
// every result, and results are compared in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module caching_lock_grant_table_core_tb import clgt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1400;
  localparam int DIRECTED_ROWS = 22;

  typedef struct packed {
    logic [1:0] status;
    logic       send;
    client_t    target;
    client_t    succ;
  } grant_result_t;

  typedef struct packed {
    logic          op;
    lock_idx_t     ln;
    client_t       cl;
    logic          typed;
    grant_result_t res;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       opcode = OP_ACQUIRE;
  logic [7:0] lock_number = '0;
  logic [3:0] client = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] status;
  logic       revoke_send;
  logic [3:0] revoke_target;
  logic [3:0] revoke_successor;

  // predicted table
  logic         lock_busy [LOCK_COUNT];
  logic         holder_ok [LOCK_COUNT];
  client_t      holder_id [LOCK_COUNT];
  logic         succ_ok   [LOCK_COUNT];
  client_t      succ_id   [LOCK_COUNT];
  client_mask_t wait_mask [LOCK_COUNT];

  grant_result_t pending_grants [$];
  lock_idx_t     hot_locks [4];
  int            errors = 0;
  int            results_seen = 0;
  int            items_sent = 0;

  plan_row_t plan [DIRECTED_ROWS] = '{
    '{OP_RELEASE, 8'd0,   4'd0,  1'b1, '{ST_ERROR, 1'b0, 4'd0, 4'd0}},
    '{OP_ACQUIRE, 8'd0,   4'd0,  1'b1, '{ST_OK,    1'b0, 4'd0, 4'd0}},
    '{OP_ACQUIRE, 8'd0,   4'd15, 1'b1, '{ST_RETRY, 1'b1, 4'd0, 4'd15}},
    '{OP_ACQUIRE, 8'd0,   4'd3,  1'b1, '{ST_RETRY, 1'b1, 4'd0, 4'd15}},
    '{OP_ACQUIRE, 8'd0,   4'd5,  1'b0, '0},
    '{OP_RELEASE, 8'd0,   4'd15, 1'b1, '{ST_ERROR, 1'b0, 4'd0, 4'd0}},
    '{OP_RELEASE, 8'd0,   4'd0,  1'b1, '{ST_OK,    1'b0, 4'd0, 4'd0}},
    '{OP_ACQUIRE, 8'd0,   4'd3,  1'b0, '0},
    '{OP_ACQUIRE, 8'd0,   4'd15, 1'b0, '0},
    '{OP_ACQUIRE, 8'd0,   4'd15, 1'b0, '0},
    '{OP_RELEASE, 8'd0,   4'd15, 1'b0, '0},
    '{OP_ACQUIRE, 8'd0,   4'd3,  1'b0, '0},
    '{OP_ACQUIRE, 8'd255, 4'd15, 1'b1, '{ST_OK,    1'b0, 4'd0, 4'd0}},
    '{OP_ACQUIRE, 8'd255, 4'd15, 1'b0, '0},
    '{OP_RELEASE, 8'd255, 4'd15, 1'b0, '0},
    '{OP_ACQUIRE, 8'd255, 4'd15, 1'b0, '0},
    '{OP_RELEASE, 8'd255, 4'd0,  1'b1, '{ST_ERROR, 1'b0, 4'd0, 4'd0}},
    '{OP_RELEASE, 8'd255, 4'd15, 1'b1, '{ST_OK,    1'b0, 4'd0, 4'd0}},
    '{OP_ACQUIRE, 8'd170, 4'd10, 1'b1, '{ST_OK,    1'b0, 4'd0, 4'd0}},
    '{OP_ACQUIRE, 8'd85,  4'd5,  1'b1, '{ST_OK,    1'b0, 4'd0, 4'd0}},
    '{OP_ACQUIRE, 8'd170, 4'd5,  1'b0, '0},
    '{OP_RELEASE, 8'd85,  4'd10, 1'b1, '{ST_ERROR, 1'b0, 4'd0, 4'd0}}
  };

  caching_lock_grant_table_core uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .lock_number      (lock_number),
    .client           (client),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .revoke_send      (revoke_send),
    .revoke_target    (revoke_target),
    .revoke_successor (revoke_successor)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic grant_result_t predict_grant(logic op, lock_idx_t ln, client_t cl);
    grant_result_t r;
    logic          res_free;
    logic          revoke;
    client_t       nx;
    r = '0;
    revoke = 1'b0;
    nx = '0;
    if (op == OP_RELEASE) begin
      if (!lock_busy[ln] || !holder_ok[ln] || holder_id[ln] != cl) begin
        r.status = ST_ERROR;
      end else begin
        lock_busy[ln] = 1'b0;
        holder_ok[ln] = 1'b0;
        holder_id[ln] = '0;
        r.status = ST_OK;
      end
      return r;
    end
    res_free = !succ_ok[ln] || succ_id[ln] == cl;
    if (!lock_busy[ln] && res_free) begin
      lock_busy[ln] = 1'b1;
      holder_ok[ln] = 1'b1;
      holder_id[ln] = cl;
      succ_ok[ln] = 1'b0;
      succ_id[ln] = '0;
      wait_mask[ln][cl] = 1'b0;
      if (wait_mask[ln] != '0) begin
        for (int i = CLIENT_COUNT - 1; i >= 0; i--) begin
          if (wait_mask[ln][i]) nx = client_t'(i);
        end
        revoke = 1'b1;
        succ_ok[ln] = 1'b1;
        succ_id[ln] = nx;
        wait_mask[ln][nx] = 1'b0;
      end
      r.status = ST_OK;
    end else if (res_free) begin
      succ_ok[ln] = 1'b1;
      succ_id[ln] = cl;
      wait_mask[ln][cl] = 1'b0;
      revoke = 1'b1;
      r.status = ST_RETRY;
    end else begin
      wait_mask[ln][cl] = 1'b1;
      revoke = 1'b1;
      r.status = ST_RETRY;
    end
    if (revoke && holder_ok[ln]) begin
      r.send = 1'b1;
      r.target = holder_id[ln];
      r.succ = succ_ok[ln] ? succ_id[ln] : '0;
    end
    return r;
  endfunction

  // mostly traffic on a few hot locks, releases mostly by the holder
  task automatic pick_request(output logic op, output lock_idx_t ln, output client_t cl);
    int pick;
    int sub;
    pick = $urandom_range(99);
    sub = $urandom_range(99);
    if (pick < 15) begin
      op = logic'($urandom_range(1));
      ln = lock_idx_t'($urandom_range(255));
      cl = client_t'($urandom_range(15));
      return;
    end
    ln = hot_locks[$urandom_range(3)];
    cl = client_t'($urandom_range(15));
    op = OP_ACQUIRE;
    if (lock_busy[ln] && sub < 45) begin
      op = OP_RELEASE;
      cl = holder_id[ln];
    end else if (sub < 52) begin
      op = OP_RELEASE;
    end else if (succ_ok[ln] && sub < 80) begin
      cl = succ_id[ln];
    end
  endtask

  task automatic send_request(logic op, lock_idx_t ln, client_t cl, logic typed,
                              grant_result_t typed_res, logic quiet);
    grant_result_t pred;
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    lock_number <= ln;
    client <= cl;
    do @(posedge clk); while (!in_ready);
    pred = predict_grant(op, ln, cl);
    pending_grants.push_back(typed ? typed_res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  // result checking
  always @(posedge clk) begin
    grant_result_t exp_res;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_grants.size() == 0) begin
        $error("unexpected result transfer: status %0d", status);
        errors++;
      end else begin
        exp_res = pending_grants.pop_front();
        if (status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status);
          errors++;
        end
        if (revoke_send !== exp_res.send) begin
          $error("revoke_send: expected %0d, actual %0d", exp_res.send, revoke_send);
          errors++;
        end
        if (revoke_target !== exp_res.target) begin
          $error("revoke_target: expected %0d, actual %0d", exp_res.target, revoke_target);
          errors++;
        end
        if (revoke_successor !== exp_res.succ) begin
          $error("revoke_successor: expected %0d, actual %0d", exp_res.succ,
                 revoke_successor);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, one quiet window
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= 900 && results_seen < 1100) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 23);
      end
      @(negedge clk);
    end
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    op_loop_vars: begin
      logic      op;
      lock_idx_t ln;
      client_t   cl;
      for (int i = 0; i < LOCK_COUNT; i++) begin
        lock_busy[i] = 1'b0;
        holder_ok[i] = 1'b0;
        holder_id[i] = '0;
        succ_ok[i] = 1'b0;
        succ_id[i] = '0;
        wait_mask[i] = '0;
      end
      for (int i = 0; i < 4; i++) hot_locks[i] = lock_idx_t'($urandom_range(255));
      repeat (7) @(posedge clk);
      @(negedge clk);
      rst <= 1'b0;
      @(negedge clk);

      foreach (plan[i]) begin
        send_request(plan[i].op, plan[i].ln, plan[i].cl, plan[i].typed, plan[i].res, 1'b0);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        if (n == 600) begin
          in_valid <= 1'b0;
          while (pending_grants.size() != 0) @(negedge clk);
        end
        pick_request(op, ln, cl);
        send_request(op, ln, cl, 1'b0, '0, n >= 900 && n < 1100);
      end
      in_valid <= 1'b0;

      while (pending_grants.size() != 0) @(posedge clk);
      repeat (10) @(posedge clk);
      if (errors == 0 && pending_grants.size() == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
      $finish;
    end
  end

endmodule

`default_nettype wire
